>>> sv/sfp_pkg.sv
// Shared types and codes for the sync frame parser.
package sfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam logic [7:0]  ACCEPTED_CLASS_RST = 8'd1;
   localparam logic [15:0] MAX_PAYLOAD_RST    = 16'd1020;

   // byte roles
   localparam logic [2:0] ROLE_NONE    = 3'd0;
   localparam logic [2:0] ROLE_CLASS   = 3'd1;
   localparam logic [2:0] ROLE_ID      = 3'd2;
   localparam logic [2:0] ROLE_LENLO   = 3'd3;
   localparam logic [2:0] ROLE_LENHI   = 3'd4;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
   localparam logic [2:0] ROLE_CKA     = 3'd6;
   localparam logic [2:0] ROLE_CKB     = 3'd7;

   // frame status
   localparam logic [2:0] ST_NONE        = 3'd0;
   localparam logic [2:0] ST_DELIVERED   = 3'd1;
   localparam logic [2:0] ST_NOT_HANDLED = 3'd2;
   localparam logic [2:0] ST_BAD_A       = 3'd3;
   localparam logic [2:0] ST_BAD_B       = 3'd4;
   localparam logic [2:0] ST_TOO_LONG    = 3'd5;

   // register indexes (paddr bit 2)
   localparam logic REG_ACCEPTED_CLASS = 1'b0;
   localparam logic REG_MAX_PAYLOAD    = 1'b1;

   typedef struct packed {
      logic [7:0]  accepted_class;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [2:0]  byte_role;
      logic [15:0] payload_index;
      logic [7:0]  frame_class;
      logic [15:0] frame_length;
      logic        frame_end;
      logic [2:0]  frame_status;
   } rsp_type;

endpackage

>>> sv/sfp_csr.sv
// Configuration registers behind the APB-style port.
module sfp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output sfp_pkg::cfg_type   cfg
);

   sfp_pkg::cfg_type cfg_ff;
   sfp_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            sfp_pkg::REG_ACCEPTED_CLASS: cfg_in.accepted_class = csr_pwdata[7:0];
            sfp_pkg::REG_MAX_PAYLOAD:    cfg_in.max_payload    = csr_pwdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         sfp_pkg::REG_ACCEPTED_CLASS: csr_prdata = {24'd0, cfg_ff.accepted_class};
         sfp_pkg::REG_MAX_PAYLOAD:    csr_prdata = {16'd0, cfg_ff.max_payload};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accepted_class <= sfp_pkg::ACCEPTED_CLASS_RST;
         cfg_ff.max_payload    <= sfp_pkg::MAX_PAYLOAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/sfp_parser.sv
// Frame parser state machine, Fletcher-8 sums and result register.
module sfp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_go,
   input  logic               func,
   input  logic [7:0]         rx_byte,
   input  sfp_pkg::cfg_type   cfg,
   output sfp_pkg::rsp_type   rsp
);

   typedef enum logic [3:0] {
      PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LENLO,
      PH_LENHI, PH_PAYLOAD, PH_CKA, PH_CKB
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       sum_a_ff, sum_a_in;
   logic [7:0]       sum_b_ff, sum_b_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      cnt_ff, cnt_in;
   logic [7:0]       class_ff, class_in;
   sfp_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]  sum_a_add;
   logic [7:0]  sum_b_add;
   logic [15:0] len_full;
   logic [15:0] cnt_inc;

   assign sum_a_add = sum_a_ff + rx_byte;
   assign sum_b_add = sum_b_ff + sum_a_add;
   assign len_full  = {rx_byte, len_ff[7:0]};
   assign cnt_inc   = cnt_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      class_in = class_ff;

      rsp_in.data_byte     = rx_byte;
      rsp_in.byte_role     = sfp_pkg::ROLE_NONE;
      rsp_in.payload_index = 16'd0;
      rsp_in.frame_class   = 8'd0;
      rsp_in.frame_length  = 16'd0;
      rsp_in.frame_end     = 1'b0;
      rsp_in.frame_status  = sfp_pkg::ST_NONE;

      if (func) begin
         // restart: back to the hunt, all fields zero
         phase_in = PH_HUNT;
         sum_a_in = 8'd0;
         sum_b_in = 8'd0;
         len_in   = 16'd0;
         cnt_in   = 16'd0;
         class_in = 8'd0;
         rsp_in.data_byte = 8'd0;
      end else begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (rx_byte == sfp_pkg::SYNC_SECOND) begin
                  sum_a_in = 8'd0;
                  sum_b_in = 8'd0;
                  len_in   = 16'd0;
                  cnt_in   = 16'd0;
                  class_in = 8'd0;
                  phase_in = PH_CLASS;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CLASS: begin
               rsp_in.byte_role = sfp_pkg::ROLE_CLASS;
               class_in = rx_byte;
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               phase_in = PH_ID;
            end
            PH_ID: begin
               rsp_in.byte_role = sfp_pkg::ROLE_ID;
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               rsp_in.byte_role    = sfp_pkg::ROLE_LENLO;
               sum_a_in            = sum_a_add;
               sum_b_in            = sum_b_add;
               len_in              = {8'd0, rx_byte};
               rsp_in.frame_length = {8'd0, rx_byte};
               phase_in            = PH_LENHI;
            end
            PH_LENHI: begin
               rsp_in.byte_role    = sfp_pkg::ROLE_LENHI;
               sum_a_in            = sum_a_add;
               sum_b_in            = sum_b_add;
               len_in              = len_full;
               rsp_in.frame_length = len_full;
               cnt_in              = 16'd0;
               if (len_full > cfg.max_payload) begin
                  rsp_in.frame_end    = 1'b1;
                  rsp_in.frame_status = sfp_pkg::ST_TOO_LONG;
                  phase_in            = PH_HUNT;
               end else if (len_full == 16'd0) begin
                  phase_in = PH_CKA;   // empty payload
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               rsp_in.byte_role     = sfp_pkg::ROLE_PAYLOAD;
               rsp_in.frame_length  = len_ff;
               rsp_in.payload_index = cnt_ff;
               sum_a_in             = sum_a_add;
               sum_b_in             = sum_b_add;
               cnt_in               = cnt_inc;
               if (cnt_inc >= len_ff) begin
                  phase_in = PH_CKA;
               end
            end
            PH_CKA: begin
               rsp_in.byte_role    = sfp_pkg::ROLE_CKA;
               rsp_in.frame_length = len_ff;
               if (rx_byte == sum_a_ff) begin
                  phase_in = PH_CKB;
               end else begin
                  rsp_in.frame_end    = 1'b1;
                  rsp_in.frame_status = sfp_pkg::ST_BAD_A;
                  phase_in            = PH_HUNT;
               end
            end
            PH_CKB: begin
               rsp_in.byte_role    = sfp_pkg::ROLE_CKB;
               rsp_in.frame_length = len_ff;
               rsp_in.frame_end    = 1'b1;
               if (rx_byte != sum_b_ff) begin
                  rsp_in.frame_status = sfp_pkg::ST_BAD_B;
               end else if (class_ff == cfg.accepted_class) begin
                  rsp_in.frame_status = sfp_pkg::ST_DELIVERED;
               end else begin
                  rsp_in.frame_status = sfp_pkg::ST_NOT_HANDLED;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               // sync hunt
               phase_in = (rx_byte == sfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
         if (rsp_in.byte_role != sfp_pkg::ROLE_NONE) begin
            rsp_in.frame_class = class_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         len_ff   <= 16'd0;
         cnt_ff   <= 16'd0;
         class_ff <= 8'd0;
      end else if (step_go) begin
         phase_ff <= phase_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         class_ff <= class_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> sv/sync_frame_parser_fletcher8.sv
// Top level of the sync frame parser with Fletcher-8 check.
//
// Request channel (req_): one item per byte; req_func = 1 restarts the parser
// to the sync hunt, otherwise req_rx_byte is parsed. Response channel (rsp_):
// exactly one item per request item, in order, giving the byte echo, its
// role, payload index, frame class and length, and an end flag with status.
// Both channels: an item moves on a clock edge with valid high and stall low.
//
// An accepted item sits in the input register and is parsed once the result
// register is free (state update and result register load together); it is
// then offered on rsp_ from the result register.
// Throughput: one item per cycle while rsp_stall stays low; the single parse
// step is the only work. When the receiver stalls, the result register holds;
// the input register then fills, and req_stall rises once both are occupied.
// Reset (synchronous, active high) empties both registers, returns the
// parser to the sync hunt with cleared sums, and loads accepted_class = 1,
// max_payload = 1020. Registers sit at csr_paddr 0 and 4; write them only
// while no item is in flight.
module sync_frame_parser_fletcher8 (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_byte_role,
   output logic [15:0] rsp_payload_index,
   output logic [7:0]  rsp_frame_class,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_frame_status,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sfp_pkg::cfg_type cfg;
   sfp_pkg::rsp_type rsp;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;
   // result register valid
   logic       out_valid_ff, out_valid_in;

   logic out_free;   // result register can take a new item this cycle
   logic step_go;    // input item is parsed into the result register
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step_go) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_rx_byte;
      end
   end

   sfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_go (step_go),
      .func    (in_func_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .rsp     (rsp)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_role     = rsp.byte_role;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_frame_class   = rsp.frame_class;
   assign rsp_frame_length  = rsp.frame_length;
   assign rsp_frame_end     = rsp.frame_end;
   assign rsp_frame_status  = rsp.frame_status;

endmodule

>>> tb/sync_frame_parser_fletcher8_tb.sv
// Self-checking testbench for the sync frame parser with Fletcher-8 check.
`timescale 1ns / 100ps

module sync_frame_parser_fletcher8_tb;

   localparam int CYCLE_LIMIT = 300000;
   // idle wait after the last echo before touching registers
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [3:0] {
      P_HUNT, P_SYNC2, P_CLASS, P_ID, P_LENLO, P_LENHI, P_PAYLOAD, P_CKA, P_CKB
   } parse_phase_type;

   // check byte corruption applied by the frame builder
   typedef enum int {CK_GOOD, CK_BREAK_A, CK_BREAK_B} ck_fault_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_byte_role;
   logic [15:0] rsp_payload_index;
   logic [7:0]  rsp_frame_class;
   logic [15:0] rsp_frame_length;
   logic        rsp_frame_end;
   logic [2:0]  rsp_frame_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sync_frame_parser_fletcher8 u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_role     (rsp_byte_role),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_frame_status  (rsp_frame_status),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // ---------------------------------------------------------------
   // Parser shadow: register copies and parse state
   // ---------------------------------------------------------------
   logic [7:0]      cfg_class = sfp_pkg::ACCEPTED_CLASS_RST;
   logic [15:0]     cfg_max_len = sfp_pkg::MAX_PAYLOAD_RST;
   parse_phase_type parse_state = P_HUNT;
   logic [7:0]      run_sum_a = 8'd0;
   logic [7:0]      run_sum_b = 8'd0;
   logic [15:0]     len_field = 16'd0;
   logic [15:0]     pay_count = 16'd0;
   logic [7:0]      cls_seen = 8'd0;

   sfp_pkg::rsp_type expected_echo_q[$];   // one per accepted item, oldest first
   sfp_pkg::rsp_type echo_exp;
   logic [7:0]       frame_q[$];           // bytes of the frame being sent

   int send_gap_pct = 0;    // chance per cycle that the sender holds off
   int rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
   int items_sent = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_parse_state();
      parse_state = P_HUNT;
      run_sum_a = 8'd0;
      run_sum_b = 8'd0;
      len_field = 16'd0;
      pay_count = 16'd0;
      cls_seen = 8'd0;
   endfunction

   function automatic void fletcher_add(input logic [7:0] b);
      run_sum_a = run_sum_a + b;
      run_sum_b = run_sum_b + run_sum_a;
   endfunction

   // Advance the shadow parser by one item and return the echo it should give.
   function automatic sfp_pkg::rsp_type predict_parse(input logic func,
                                                      input logic [7:0] b);
      sfp_pkg::rsp_type r;
      r = '0;
      if (func) begin
         // restart: hunt again, echo is all zero
         clear_parse_state();
         return r;
      end
      r.data_byte = b;
      case (parse_state)
         P_SYNC2: begin
            // anything but the second sync byte drops back, even another B5
            if (b == sfp_pkg::SYNC_SECOND) begin
               clear_parse_state();
               parse_state = P_CLASS;
            end else begin
               parse_state = P_HUNT;
            end
         end
         P_CLASS: begin
            r.byte_role = sfp_pkg::ROLE_CLASS;
            cls_seen = b;
            fletcher_add(b);
            parse_state = P_ID;
         end
         P_ID: begin
            r.byte_role = sfp_pkg::ROLE_ID;
            fletcher_add(b);
            parse_state = P_LENLO;
         end
         P_LENLO: begin
            r.byte_role = sfp_pkg::ROLE_LENLO;
            fletcher_add(b);
            len_field = {8'h00, b};
            r.frame_length = len_field;
            parse_state = P_LENHI;
         end
         P_LENHI: begin
            r.byte_role = sfp_pkg::ROLE_LENHI;
            fletcher_add(b);
            len_field[15:8] = b;
            r.frame_length = len_field;
            pay_count = 16'd0;
            if (len_field > cfg_max_len) begin
               r.frame_end = 1'b1;
               r.frame_status = sfp_pkg::ST_TOO_LONG;
               parse_state = P_HUNT;
            end else if (len_field == 16'd0) begin
               parse_state = P_CKA;
            end else begin
               parse_state = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            r.byte_role = sfp_pkg::ROLE_PAYLOAD;
            r.frame_length = len_field;
            r.payload_index = pay_count;
            fletcher_add(b);
            pay_count = pay_count + 16'd1;
            if (pay_count >= len_field) parse_state = P_CKA;
         end
         P_CKA: begin
            r.byte_role = sfp_pkg::ROLE_CKA;
            r.frame_length = len_field;
            if (b == run_sum_a) begin
               parse_state = P_CKB;
            end else begin
               r.frame_end = 1'b1;
               r.frame_status = sfp_pkg::ST_BAD_A;
               parse_state = P_HUNT;
            end
         end
         P_CKB: begin
            r.byte_role = sfp_pkg::ROLE_CKB;
            r.frame_length = len_field;
            r.frame_end = 1'b1;
            if (b != run_sum_b) r.frame_status = sfp_pkg::ST_BAD_B;
            else if (cls_seen == cfg_class) r.frame_status = sfp_pkg::ST_DELIVERED;
            else r.frame_status = sfp_pkg::ST_NOT_HANDLED;
            parse_state = P_HUNT;
         end
         default: begin
            parse_state = (b == sfp_pkg::SYNC_FIRST) ? P_SYNC2 : P_HUNT;
         end
      endcase
      if (r.byte_role != sfp_pkg::ROLE_NONE) r.frame_class = cls_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Result checking and receiver stall
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t ERROR %s expected %h actual %h", $time, name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_echo_q.size() == 0) begin
            $display("%0t ERROR unexpected item expected none actual %h", $time,
                     {rsp_data_byte, rsp_byte_role, rsp_payload_index,
                      rsp_frame_class, rsp_frame_length, rsp_frame_end,
                      rsp_frame_status});
            mismatch_count++;
         end else begin
            echo_exp = expected_echo_q.pop_front();
            check_field("data_byte", 16'(echo_exp.data_byte), 16'(rsp_data_byte));
            check_field("byte_role", 16'(echo_exp.byte_role), 16'(rsp_byte_role));
            check_field("payload_index", echo_exp.payload_index, rsp_payload_index);
            check_field("frame_class", 16'(echo_exp.frame_class),
                        16'(rsp_frame_class));
            check_field("frame_length", echo_exp.frame_length, rsp_frame_length);
            check_field("frame_end", 16'(echo_exp.frame_end), 16'(rsp_frame_end));
            check_field("frame_status", 16'(echo_exp.frame_status),
                        16'(rsp_frame_status));
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ERROR watchdog expired, %0d items outstanding", $time,
                  expected_echo_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Offer one item, hold it through stalls, log the expected echo on accept.
   task automatic send_byte(input logic func, input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      expected_echo_q.push_back(predict_parse(func, b));
      items_sent++;
   endtask

   // Drop valid and wait until every echo is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_echo_q.size() != 0) @(posedge clock);
   endtask

   // Sync, header, payload and check bytes into frame_q. Payload is left out
   // when with_payload is low (oversize frames stop at the length anyway).
   task automatic build_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input logic with_payload,
                              input ck_fault_type fault);
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] body[$];
      ck_a = 8'd0;
      ck_b = 8'd0;
      body = '{cls, id, len[7:0], len[15:8]};
      if (with_payload)
         for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
      foreach (body[i]) begin
         ck_a = ck_a + body[i];
         ck_b = ck_b + ck_a;
      end
      if (fault == CK_BREAK_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (fault == CK_BREAK_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      frame_q.delete();
      frame_q.push_back(sfp_pkg::SYNC_FIRST);
      frame_q.push_back(sfp_pkg::SYNC_SECOND);
      foreach (body[i]) frame_q.push_back(body[i]);
      frame_q.push_back(ck_a);
      frame_q.push_back(ck_b);
   endtask

   task automatic send_frame_bytes(input int count);
      for (int i = 0; i < count && i < frame_q.size(); i++) send_byte(1'b0, frame_q[i]);
   endtask

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------
   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input logic idx);
      logic [31:0] rd;
      logic [31:0] want;
      want = (idx == sfp_pkg::REG_ACCEPTED_CLASS) ? {24'd0, cfg_class}
                                                  : {16'd0, cfg_max_len};
      csr_access(1'b0, idx, 32'd0, rd);
      if (rd !== want) begin
         $display("%0t ERROR register %0d expected %h actual %h", $time, idx, want, rd);
         mismatch_count++;
      end
   endtask

   // Write a register with the parser quiet, then read it back.
   task automatic set_register(input logic idx, input logic [31:0] value);
      logic [31:0] unused_rd;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, idx, value, unused_rd);
      if (idx == sfp_pkg::REG_ACCEPTED_CLASS) cfg_class = value[7:0];
      else cfg_max_len = value[15:0];
      check_register(idx);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_register_defaults();
      check_register(sfp_pkg::REG_ACCEPTED_CLASS);
      check_register(sfp_pkg::REG_MAX_PAYLOAD);
   endtask

   // Accepted class, one-byte payload: every role, status delivered.
   task automatic test_delivered_frame();
      build_frame(sfp_pkg::ACCEPTED_CLASS_RST, 8'hFF, 16'd1, 1'b1, CK_GOOD);
      send_frame_bytes(frame_q.size());
   endtask

   // Zero length goes straight to check A, which is wrong here.
   task automatic test_empty_bad_check_a();
      build_frame(8'hFF, 8'h00, 16'd0, 1'b1, CK_BREAK_A);
      send_frame_bytes(7);
   endtask

   // Length FFFF is above the reset limit: frame ends at the length high byte.
   task automatic test_oversize();
      build_frame(8'h00, 8'h7F, 16'hFFFF, 1'b0, CK_GOOD);
      send_frame_bytes(6);
   endtask

   // B5 B5 62 is not a sync; then a restart in the middle of a header.
   task automatic test_broken_sync_restart();
      send_byte(1'b0, sfp_pkg::SYNC_FIRST);
      send_byte(1'b0, sfp_pkg::SYNC_FIRST);
      send_byte(1'b0, sfp_pkg::SYNC_SECOND);
      send_byte(1'b0, sfp_pkg::SYNC_FIRST);
      send_byte(1'b0, sfp_pkg::SYNC_SECOND);
      send_byte(1'b0, 8'h01);
      send_byte(1'b1, 8'($urandom_range(255)));
   endtask

   // Mostly framed traffic with random content; some frames carry bad
   // checks, some are cut short, the rest is loose bytes and restarts.
   task automatic test_random_stream(input int n_items);
      int start_count;
      int pick;
      int cut;
      logic [15:0] len;
      logic [7:0] cls;
      logic oversize;
      ck_fault_type fault;
      start_count = items_sent;
      while (items_sent - start_count < n_items) begin
         pick = int'($urandom_range(99));
         if (pick < 80) begin
            cls = ($urandom_range(1)) ? cfg_class : 8'($urandom_range(255));
            pick = int'($urandom_range(99));
            if (pick < 8 && cfg_max_len != 16'hFFFF)
               len = 16'($urandom_range(int'(cfg_max_len) + 1, 65535));
            else if (pick < 11)
               len = 16'($urandom_range(0, (cfg_max_len < 100) ? cfg_max_len : 100));
            else
               len = 16'($urandom_range(0, (cfg_max_len < 6) ? cfg_max_len : 6));
            oversize = (len > cfg_max_len);
            pick = int'($urandom_range(99));
            fault = (pick < 10) ? CK_BREAK_A : (pick < 20) ? CK_BREAK_B : CK_GOOD;
            build_frame(cls, 8'($urandom_range(255)), len, !oversize, fault);
            cut = oversize ? int'($urandom_range(6, 8)) : frame_q.size();
            if ($urandom_range(99) < 10) begin
               // truncated frame, often followed by a restart
               cut = int'($urandom_range(1, cut - 1));
               send_frame_bytes(cut);
               if ($urandom_range(1)) send_byte(1'b1, 8'($urandom_range(255)));
            end else begin
               send_frame_bytes(cut);
            end
         end else if (pick < 93) begin
            send_byte(1'b0, ($urandom_range(99) < 30) ? sfp_pkg::SYNC_FIRST
                                                     : 8'($urandom_range(255)));
         end else begin
            send_byte(1'b1, 8'($urandom_range(255)));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver stalls heavily
      send_gap_pct = 22;
      rsp_stall_pct = 75;
      test_register_defaults();
      test_delivered_frame();
      test_empty_bad_check_a();
      test_oversize();
      test_broken_sync_restart();
      test_random_stream(280);

      // lowest register settings: only empty frames fit
      set_register(sfp_pkg::REG_ACCEPTED_CLASS, 32'd0);
      set_register(sfp_pkg::REG_MAX_PAYLOAD, 32'd0);
      test_random_stream(150);

      // roles swapped; highest settings allow longer payloads
      send_gap_pct = 75;
      rsp_stall_pct = 22;
      set_register(sfp_pkg::REG_ACCEPTED_CLASS, 32'd255);
      set_register(sfp_pkg::REG_MAX_PAYLOAD, 32'd65535);
      test_random_stream(250);

      // no idling at all; sender drains completely once midway
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      set_register(sfp_pkg::REG_ACCEPTED_CLASS, 32'($urandom_range(255)));
      set_register(sfp_pkg::REG_MAX_PAYLOAD, 32'($urandom_range(1, 40)));
      test_random_stream(150);
      wait_idle();
      test_random_stream(150);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
